[sv/nns_pkg.sv]
// Package for the nearest-neighbour scaler: field widths, coordinate limit
// and default fraction width shared by all scaler modules.
// Depends on nothing.
package nns_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int FRAC_BITS_DEF = 16;

    // Position, rectangle-size and coordinate widths all follow MAX_DIM.
    localparam int POS_W    = $clog2(MAX_DIM);
    localparam int DIM_W    = POS_W + 1;
    localparam int COORD_W  = $clog2(2 * MAX_DIM);
    localparam int PITCH_W  = 15;
    localparam int BPP_W    = 3;
    localparam int OFFSET_W = 28;
    localparam int CFG_W    = PITCH_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [COORD_W-1:0] COORD_LIMIT = COORD_W'(2 * MAX_DIM - 1);

endpackage

[sv/nns_step_div.sv]
// Iterative restoring divider that forms one 13.16 step: (size << FRAC_BITS) / span.
// One quotient bit per cycle. Depends on nns_pkg.
module nns_step_div
    import nns_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         launch,
    input  logic [DIM_W-1:0]             size,
    input  logic [DIM_W-1:0]             span,
    output logic                         running,
    output logic [DIM_W+FRAC_BITS-1:0]   step
);

    localparam int QW    = DIM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QW);

    typedef enum logic {DIV_IDLE, DIV_RUN} div_state_t;

    div_state_t        state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [QW-1:0]     work_reg;
    logic [DIM_W-1:0]  rem_reg;

    logic [DIM_W:0]    trial;
    logic [DIM_W:0]    diff;
    logic              fits;

    // Bring down the next dividend bit and try a subtraction.
    always_comb
    begin
        trial = {rem_reg, work_reg[QW-1]};
        diff  = trial - {1'b0, span};
        fits  = (trial >= {1'b0, span});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            count_reg <= '0;
            work_reg  <= QW'(1) << FRAC_BITS;
            rem_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                DIV_IDLE:
                begin
                    if (launch)
                    begin
                        state_reg <= DIV_RUN;
                        count_reg <= CNT_W'(QW - 1);
                        work_reg  <= {size, {FRAC_BITS{1'b0}}};
                        rem_reg   <= '0;
                    end
                end
                DIV_RUN:
                begin
                    work_reg <= {work_reg[QW-2:0], fits};
                    rem_reg  <= fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
                    if (count_reg == '0)
                    begin
                        state_reg <= DIV_IDLE;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    assign running = (state_reg == DIV_RUN);
    assign step    = work_reg;

endmodule

[sv/nns_axis_map.sv]
// One axis of the scaler: position times step, scaled down, offset by the
// rectangle origin and saturated. Two register stages. Depends on nns_pkg.
module nns_axis_map
    import nns_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic [POS_W-1:0]             pos,
    input  logic [DIM_W+FRAC_BITS-1:0]   step,
    input  logic [POS_W-1:0]             base,
    output logic [COORD_W-1:0]           coord
);

    localparam int STEP_W = DIM_W + FRAC_BITS;
    localparam int PROD_W = POS_W + STEP_W;
    localparam int SUM_W  = PROD_W - FRAC_BITS + 1;

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [SUM_W-1:0]   sum;
    logic [COORD_W-1:0] coord_reg;
    logic [COORD_W-1:0] coord_next;

    always_comb
    begin
        prod_next  = {{STEP_W{1'b0}}, pos} * {{POS_W{1'b0}}, step};
        sum        = SUM_W'(base) + {1'b0, prod_reg[PROD_W-1:FRAC_BITS]};
        coord_next = (sum > SUM_W'(COORD_LIMIT)) ? COORD_LIMIT : sum[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        coord_reg <= coord_next;
    end

    assign coord = coord_reg;

endmodule

[sv/nns_offset.sv]
// Source byte offset: row times pitch plus column times bytes per pixel,
// forced to zero for positions outside the rectangle. Two register stages.
// Depends on nns_pkg.
module nns_offset
    import nns_pkg::*;
(
    input  logic                  clk,
    input  logic [COORD_W-1:0]    col,
    input  logic [COORD_W-1:0]    row,
    input  logic [PITCH_W-1:0]    pitch,
    input  logic [BPP_W-1:0]      pixel_bytes,
    input  logic                  clear,
    output logic [OFFSET_W-1:0]   offset
);

    localparam int COLT_W = COORD_W + BPP_W;

    logic [BPP_W-1:0]    bpp;
    logic [OFFSET_W-1:0] row_term_reg;
    logic [OFFSET_W-1:0] row_term_next;
    logic [COLT_W-1:0]   col_term_reg;
    logic [COLT_W-1:0]   col_term_next;
    logic                clear_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;

    // Zero bytes per pixel counts as one, anything above four as four.
    always_comb
    begin
        case (pixel_bytes) inside
            3'd0:          bpp = BPP_W'(1);
            [3'd1:3'd4]:   bpp = pixel_bytes;
            default:       bpp = BPP_W'(4);
        endcase
    end

    // The clear flag is registered beside the two products so that it
    // stays with the item it belongs to.
    always_comb
    begin
        row_term_next = {{(OFFSET_W-COORD_W){1'b0}}, row}
                      * {{(OFFSET_W-PITCH_W){1'b0}}, pitch};
        col_term_next = {{BPP_W{1'b0}}, col} * {{COORD_W{1'b0}}, bpp};
        offset_next   = clear_reg ? '0 : (row_term_reg + OFFSET_W'(col_term_reg));
    end

    always_ff @(posedge clk)
    begin
        row_term_reg <= row_term_next;
        col_term_reg <= col_term_next;
        clear_reg    <= clear;
        offset_reg   <= offset_next;
    end

    assign offset = offset_reg;

endmodule

[sv/nearest_neighbor_scaler.sv]
// Top level of the nearest-neighbour scaler address generator.
// Uses nns_pkg, nns_step_div, nns_axis_map and nns_offset.
//
// The scaler takes one destination position per clock while busy is low
// and returns its nearest source pixel after five register stages: a
// transfer is accepted on a rising edge with start high and busy low, and
// its result appears on src_col, src_row, src_byte_offset and outside_rect
// for exactly one cycle with done high. The receiver cannot hold results
// back, so it must take every result in the cycle it is shown.
// The rate is one transfer per clock while busy is low. The five stages
// are: input capture and rectangle test, the two step multiplications,
// the scale-down with origin add and saturation, the pitch and pixel-size
// multiplications, and the final offset add. The horizontal and vertical
// steps are held in registers and recomputed by two bit-serial dividers
// whenever a size register (source or target width or height) is written;
// busy is then high from the write cycle until both dividers have finished,
// and no transfer is taken in that time. Writes to the other registers
// leave busy low.
// Positions outside the destination rectangle return zero fields with
// outside_rect set.
module nearest_neighbor_scaler
    import nns_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [POS_W-1:0]      dest_col,
    input  logic [POS_W-1:0]      dest_row,

    // Result channel
    output logic                  done,
    output logic [COORD_W-1:0]    src_col,
    output logic [COORD_W-1:0]    src_row,
    output logic [OFFSET_W-1:0]   src_byte_offset,
    output logic                  outside_rect,

    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    localparam int STEP_W = DIM_W + FRAC_BITS;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PITCH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES   = 3'd7;

    // Configuration registers.
    logic [POS_W-1:0]    source_left_reg;
    logic [POS_W-1:0]    source_top_reg;
    logic [DIM_W-1:0]    source_width_reg;
    logic [DIM_W-1:0]    source_height_reg;
    logic [DIM_W-1:0]    target_width_reg;
    logic [DIM_W-1:0]    target_height_reg;
    logic [PITCH_W-1:0]  source_pitch_reg;
    logic [BPP_W-1:0]    pixel_bytes_reg;

    // Step recomputation control.
    logic                size_write;
    logic                div_launch_reg;
    logic                hdiv_running;
    logic                vdiv_running;
    logic [STEP_W-1:0]   hstep;
    logic [STEP_W-1:0]   vstep;

    // Pipeline control and side-band payload.
    logic                accept;
    logic                outside_next;
    logic [4:0]          valid_reg;
    logic [3:0]          outside_pipe_reg;
    logic [POS_W-1:0]    col_s1_reg;
    logic [POS_W-1:0]    row_s1_reg;
    logic [COORD_W-1:0]  col_s3;
    logic [COORD_W-1:0]  row_s3;
    logic [COORD_W-1:0]  col_s4_reg;
    logic [COORD_W-1:0]  row_s4_reg;
    logic [COORD_W-1:0]  src_col_reg;
    logic [COORD_W-1:0]  src_row_reg;
    logic                outside_reg;
    logic [OFFSET_W-1:0] offset_s5;

    // A write to any of the four size registers invalidates both steps.
    assign size_write = cfg_we && (cfg_addr inside {REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT,
                                                    REG_TARGET_WIDTH, REG_TARGET_HEIGHT});

    assign busy   = size_write || div_launch_reg || hdiv_running || vdiv_running;
    assign accept = start && !busy;

    // An empty target rectangle makes every position fall outside.
    assign outside_next = ({1'b0, dest_col} >= target_width_reg)
                       || ({1'b0, dest_row} >= target_height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_left_reg   <= '0;
            source_top_reg    <= '0;
            source_width_reg  <= DIM_W'(1);
            source_height_reg <= DIM_W'(1);
            target_width_reg  <= DIM_W'(1);
            target_height_reg <= DIM_W'(1);
            source_pitch_reg  <= PITCH_W'(4096);
            pixel_bytes_reg   <= BPP_W'(4);
            div_launch_reg    <= 1'b0;
        end
        else
        begin
            // The dividers start in the cycle after the write, once the new
            // size is in its register.
            div_launch_reg <= size_write;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SOURCE_LEFT:   source_left_reg   <= cfg_wdata[POS_W-1:0];
                    REG_SOURCE_TOP:    source_top_reg    <= cfg_wdata[POS_W-1:0];
                    REG_SOURCE_WIDTH:  source_width_reg  <= cfg_wdata[DIM_W-1:0];
                    REG_SOURCE_HEIGHT: source_height_reg <= cfg_wdata[DIM_W-1:0];
                    REG_TARGET_WIDTH:  target_width_reg  <= cfg_wdata[DIM_W-1:0];
                    REG_TARGET_HEIGHT: target_height_reg <= cfg_wdata[DIM_W-1:0];
                    REG_SOURCE_PITCH:  source_pitch_reg  <= cfg_wdata[PITCH_W-1:0];
                    REG_PIXEL_BYTES:   pixel_bytes_reg   <= cfg_wdata[BPP_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    nns_step_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_hdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (div_launch_reg),
        .size    (source_width_reg),
        .span    (target_width_reg),
        .running (hdiv_running),
        .step    (hstep)
    );

    nns_step_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_vdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .launch  (div_launch_reg),
        .size    (source_height_reg),
        .span    (target_height_reg),
        .running (vdiv_running),
        .step    (vstep)
    );

    // Valid bits and the outside flag travel alongside the data; nothing
    // ever stalls, so they simply shift one stage per clock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            col_s1_reg <= dest_col;
            row_s1_reg <= dest_row;
        end
        outside_pipe_reg <= {outside_pipe_reg[2:0], outside_next};
        col_s4_reg       <= col_s3;
        row_s4_reg       <= row_s3;
        // Column and row results for positions outside the rectangle are zeroed here.
        src_col_reg      <= outside_pipe_reg[3] ? '0 : col_s4_reg;
        src_row_reg      <= outside_pipe_reg[3] ? '0 : row_s4_reg;
        outside_reg      <= outside_pipe_reg[3];
    end

    nns_axis_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_col_map (
        .clk   (clk),
        .pos   (col_s1_reg),
        .step  (hstep),
        .base  (source_left_reg),
        .coord (col_s3)
    );

    nns_axis_map #(
        .FRAC_BITS (FRAC_BITS)
    ) u_row_map (
        .clk   (clk),
        .pos   (row_s1_reg),
        .step  (vstep),
        .base  (source_top_reg),
        .coord (row_s3)
    );

    nns_offset u_offset (
        .clk         (clk),
        .col         (col_s3),
        .row         (row_s3),
        .pitch       (source_pitch_reg),
        .pixel_bytes (pixel_bytes_reg),
        .clear       (outside_pipe_reg[2]),
        .offset      (offset_s5)
    );

    assign done            = valid_reg[4];
    assign src_col         = src_col_reg;
    assign src_row         = src_row_reg;
    assign src_byte_offset = offset_s5;
    assign outside_rect    = outside_reg;

endmodule

[bench/scaler_checker.sv]
`timescale 1ns / 1ps
// Register map of the scaler and the result checker.
// The checker watches the command, result and configuration ports and
// predicts every result; it depends on nns_pkg and scaler_tb_pkg.
package scaler_tb_pkg;

    import nns_pkg::*;

    localparam int REG_COUNT = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SOURCE_LEFT   = 3'd0,
        REG_SOURCE_TOP    = 3'd1,
        REG_SOURCE_WIDTH  = 3'd2,
        REG_SOURCE_HEIGHT = 3'd3,
        REG_TARGET_WIDTH  = 3'd4,
        REG_TARGET_HEIGHT = 3'd5,
        REG_SOURCE_PITCH  = 3'd6,
        REG_PIXEL_BYTES   = 3'd7
    } reg_index_t;

endpackage

module scaler_checker
    import nns_pkg::*;
    import scaler_tb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [POS_W-1:0]      dest_col,
    input  logic [POS_W-1:0]      dest_row,
    input  logic                  done,
    input  logic [COORD_W-1:0]    src_col,
    input  logic [COORD_W-1:0]    src_row,
    input  logic [OFFSET_W-1:0]   src_byte_offset,
    input  logic                  outside_rect,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    failures,
    output int                    pending
);

    typedef struct packed {
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [OFFSET_W-1:0] offset;
        logic                outside;
    } source_hit_t;

    // Local copy of the configuration registers.
    logic [POS_W-1:0]   src_left;
    logic [POS_W-1:0]   src_top;
    logic [DIM_W-1:0]   src_width;
    logic [DIM_W-1:0]   src_height;
    logic [DIM_W-1:0]   tgt_width;
    logic [DIM_W-1:0]   tgt_height;
    logic [PITCH_W-1:0] src_pitch;
    logic [BPP_W-1:0]   pix_bytes;

    source_hit_t expected_hits[$];
    int          fail_count;

    // One axis: origin plus the truncated 13.16 step times the position,
    // clamped to the largest coordinate.
    function automatic logic [COORD_W-1:0] scale_axis(logic [POS_W-1:0] origin,
                                                      logic [POS_W-1:0] pos,
                                                      logic [DIM_W-1:0] size,
                                                      logic [DIM_W-1:0] span);
        logic [63:0] step_q;
        logic [63:0] coord;
        step_q = (64'(size) << FRAC_BITS_DEF) / 64'(span);
        coord  = 64'(origin) + ((64'(pos) * step_q) >> FRAC_BITS_DEF);
        if (coord > 64'(COORD_LIMIT))
            coord = 64'(COORD_LIMIT);
        return coord[COORD_W-1:0];
    endfunction

    function automatic source_hit_t predict_source(logic [POS_W-1:0] col,
                                                   logic [POS_W-1:0] row);
        source_hit_t hit;
        logic [BPP_W-1:0] bpp;
        logic [63:0] offset;
        hit = '0;
        if (DIM_W'(col) >= tgt_width || DIM_W'(row) >= tgt_height) begin
            hit.outside = 1'b1;
            return hit;
        end
        if (pix_bytes == 0)
            bpp = BPP_W'(1);
        else if (pix_bytes > 4)
            bpp = BPP_W'(4);
        else
            bpp = pix_bytes;
        hit.col = scale_axis(src_left, col, src_width, tgt_width);
        hit.row = scale_axis(src_top, row, src_height, tgt_height);
        offset = 64'(hit.row) * 64'(src_pitch) + 64'(hit.col) * 64'(bpp);
        hit.offset = offset[OFFSET_W-1:0];
        return hit;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        source_hit_t want;
        if (!rst_n) begin
            src_left   <= '0;
            src_top    <= '0;
            src_width  <= DIM_W'(1);
            src_height <= DIM_W'(1);
            tgt_width  <= DIM_W'(1);
            tgt_height <= DIM_W'(1);
            src_pitch  <= PITCH_W'(4096);
            pix_bytes  <= BPP_W'(4);
            expected_hits.delete();
            fail_count = 0;
            failures   <= 0;
            pending    <= 0;
        end
        else begin
            if (done) begin
                if (expected_hits.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none expected, actual col %0d row %0d",
                             $realtime, src_col, src_row);
                end
                else begin
                    want = expected_hits.pop_front();
                    check_field("src_col", 32'(want.col), 32'(src_col));
                    check_field("src_row", 32'(want.row), 32'(src_row));
                    check_field("src_byte_offset", 32'(want.offset), 32'(src_byte_offset));
                    check_field("outside_rect", 32'(want.outside), 32'(outside_rect));
                end
            end
            if (start && !busy)
                expected_hits.push_back(predict_source(dest_col, dest_row));
            if (cfg_we) begin
                case (reg_index_t'(cfg_addr))
                    REG_SOURCE_LEFT:   src_left   <= cfg_wdata[POS_W-1:0];
                    REG_SOURCE_TOP:    src_top    <= cfg_wdata[POS_W-1:0];
                    REG_SOURCE_WIDTH:  src_width  <= cfg_wdata[DIM_W-1:0];
                    REG_SOURCE_HEIGHT: src_height <= cfg_wdata[DIM_W-1:0];
                    REG_TARGET_WIDTH:  tgt_width  <= cfg_wdata[DIM_W-1:0];
                    REG_TARGET_HEIGHT: tgt_height <= cfg_wdata[DIM_W-1:0];
                    REG_SOURCE_PITCH:  src_pitch  <= cfg_wdata[PITCH_W-1:0];
                    REG_PIXEL_BYTES:   pix_bytes  <= cfg_wdata[BPP_W-1:0];
                    default: ;
                endcase
            end
            pending  <= expected_hits.size();
            failures <= fail_count;
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the scaler bench: clock, reset, stimulus and the final verdict.
// Depends on nns_pkg, scaler_tb_pkg, scaler_checker and the scaler itself.
module testbench;

    import nns_pkg::*;
    import scaler_tb_pkg::*;

    // The longest quiet stretch in a correct run is a busy period after a
    // size write, or a long sender gap; the limit is far beyond either.
    localparam int IDLE_LIMIT       = 2000;
    localparam int RANDOM_POSITIONS = 700;
    localparam int DRAIN_CYCLES     = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [POS_W-1:0]      dest_col;
    logic [POS_W-1:0]      dest_row;
    logic                  done;
    logic [COORD_W-1:0]    src_col;
    logic [COORD_W-1:0]    src_row;
    logic [OFFSET_W-1:0]   src_byte_offset;
    logic                  outside_rect;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    int failures;
    int pending;
    int idle_cycles;

    // The bench keeps its own idea of the destination rectangle so that most
    // random positions fall inside it and reach the mapping arithmetic.
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;

    nearest_neighbor_scaler dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .dest_col        (dest_col),
        .dest_row        (dest_row),
        .done            (done),
        .src_col         (src_col),
        .src_row         (src_row),
        .src_byte_offset (src_byte_offset),
        .outside_rect    (outside_rect),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata)
    );

    scaler_checker result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .dest_col        (dest_col),
        .dest_row        (dest_row),
        .done            (done),
        .src_col         (src_col),
        .src_row         (src_row),
        .src_byte_offset (src_byte_offset),
        .outside_rect    (outside_rect),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .failures        (failures),
        .pending         (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: any accepted transfer, result or register write counts as
    // progress. A run that goes quiet for too long has hung. The count is
    // held at zero during reset.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // A write to any of the four size registers starts the step dividers
    // and raises busy, so the task only returns once busy has dropped again
    // and the block is idle.
    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (idx == REG_TARGET_WIDTH)
            rect_width = value[DIM_W-1:0];
        else if (idx == REG_TARGET_HEIGHT)
            rect_height = value[DIM_W-1:0];
    endtask

    // Presents one position and holds it until the block takes it. Start is
    // left high so that the next position can follow straight on.
    task automatic send_position(input logic [POS_W-1:0] col,
                                 input logic [POS_W-1:0] row);
        start    <= 1'b1;
        dest_col <= col;
        dest_row <= row;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Lowers start and waits until every result still in the pipeline has
    // come out. The first edge lets the checker count the last transfer.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Register values: mostly legal settings, with the extremes and the
    // out-of-range values (zero target sizes, oversize sources, odd pixel
    // sizes, zero pitch) mixed in. Now and then junk is placed above the
    // register's own width, which the block must ignore.
    function automatic logic [CFG_W-1:0] pick_reg_value(reg_index_t idx);
        logic [CFG_W-1:0] value;
        int field_w;
        int pick;
        pick = $urandom_range(0, 9);
        case (idx)
            REG_SOURCE_LEFT, REG_SOURCE_TOP: begin
                field_w = POS_W;
                if (pick == 0)
                    value = '0;
                else if (pick == 1)
                    value = CFG_W'(MAX_DIM - 1);
                else
                    value = CFG_W'($urandom_range(0, MAX_DIM - 1));
            end
            REG_SOURCE_PITCH: begin
                field_w = PITCH_W;
                if (pick == 0)
                    value = '0;
                else if (pick == 1)
                    value = '1;
                else
                    value = CFG_W'($urandom_range(1, 16384));
            end
            REG_PIXEL_BYTES: begin
                field_w = BPP_W;
                if (pick <= 1)
                    value = CFG_W'($urandom_range(0, 7));
                else
                    value = CFG_W'($urandom_range(1, 4));
            end
            default: begin
                field_w = DIM_W;
                if (pick == 0)
                    value = '0;
                else if (pick == 1)
                    value = CFG_W'($urandom_range(MAX_DIM + 1, 2 * MAX_DIM - 1));
                else if (pick == 2)
                    value = CFG_W'(MAX_DIM);
                else if (pick == 3)
                    value = CFG_W'($urandom_range(1, 16));
                else
                    value = CFG_W'($urandom_range(1, MAX_DIM));
            end
        endcase
        if ($urandom_range(0, 7) == 0)
            value = value | (CFG_W'($urandom) & ~((CFG_W'(1) << field_w) - 1'b1));
        return value;
    endfunction

    // Positions: mostly inside the rectangle, with its last row or column,
    // the first position just outside, and fully random values mixed in.
    function automatic logic [POS_W-1:0] pick_coord(logic [DIM_W-1:0] span);
        int pick;
        int last_pos;
        pick = $urandom_range(0, 15);
        last_pos = (span > MAX_DIM) ? MAX_DIM - 1 : int'(span) - 1;
        if (span == 0 || pick < 3)
            return POS_W'($urandom);
        if (pick == 3)
            return POS_W'(last_pos);
        if (pick == 4 && span < MAX_DIM)
            return POS_W'(span);
        return POS_W'($urandom_range(0, last_pos));
    endfunction

    // A new random setting: sometimes every register, otherwise a random
    // selection, so some phases keep the previous steps.
    task automatic reconfigure();
        bit every;
        reg_index_t idx;
        every = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < REG_COUNT; i++) begin
            if (every || $urandom_range(0, 1) == 1) begin
                idx = reg_index_t'(i);
                write_reg(idx, pick_reg_value(idx));
            end
        end
    endtask

    // Sends positions in bursts of random length. About a third of the
    // bursts run straight into the next one; the others are followed by a
    // short gap, and now and then a long one, so that gaps land on every
    // stage of the pipeline.
    task automatic run_positions(input int count);
        int burst;
        int gap;
        while (count > 0) begin
            burst = $urandom_range(1, 32);
            if (burst > count)
                burst = count;
            repeat (burst)
                send_position(pick_coord(rect_width), pick_coord(rect_height));
            count -= burst;
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(7, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
    endtask

    initial begin
        int sent;
        int phase_len;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        dest_col  <= '0;
        dest_row  <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        rect_width  = DIM_W'(1);
        rect_height = DIM_W'(1);
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: a single-pixel rectangle, so only the origin is
        // inside and the far corner is well outside.
        send_position(POS_W'(0), POS_W'(0));
        send_position(POS_W'(1), POS_W'(0));
        send_position(POS_W'(0), POS_W'(1));
        send_position(POS_W'(MAX_DIM - 1), POS_W'(MAX_DIM - 1));
        drain_results();

        // Largest origin and oversize source: both coordinates saturate at
        // the far end, with the widest pitch and a pixel size above four.
        write_reg(REG_SOURCE_LEFT, CFG_W'(MAX_DIM - 1));
        write_reg(REG_SOURCE_TOP, CFG_W'(MAX_DIM - 1));
        write_reg(REG_SOURCE_WIDTH, CFG_W'(2 * MAX_DIM - 1));
        write_reg(REG_SOURCE_HEIGHT, CFG_W'(2 * MAX_DIM - 1));
        write_reg(REG_TARGET_WIDTH, CFG_W'(MAX_DIM));
        write_reg(REG_TARGET_HEIGHT, CFG_W'(MAX_DIM));
        write_reg(REG_SOURCE_PITCH, '1);
        write_reg(REG_PIXEL_BYTES, CFG_W'(7));
        send_position(POS_W'(MAX_DIM - 1), POS_W'(MAX_DIM - 1));
        send_position(POS_W'(0), POS_W'(0));
        send_position(POS_W'(MAX_DIM - 1), POS_W'(0));
        send_position(POS_W'(0), POS_W'(MAX_DIM - 1));
        send_position(POS_W'(MAX_DIM / 2), POS_W'(1));
        drain_results();

        // Empty rectangle: zero target width, then zero height as well.
        // Zero pitch and zero pixel size are set up here for later.
        write_reg(REG_SOURCE_LEFT, '0);
        write_reg(REG_SOURCE_TOP, '0);
        write_reg(REG_SOURCE_WIDTH, CFG_W'(MAX_DIM));
        write_reg(REG_SOURCE_HEIGHT, CFG_W'(1));
        write_reg(REG_TARGET_WIDTH, '0);
        write_reg(REG_SOURCE_PITCH, '0);
        write_reg(REG_PIXEL_BYTES, '0);
        send_position(POS_W'(0), POS_W'(0));
        send_position(POS_W'(MAX_DIM - 1), POS_W'(17));
        drain_results();
        write_reg(REG_TARGET_HEIGHT, '0);
        write_reg(REG_TARGET_WIDTH, CFG_W'(3000));
        send_position(POS_W'(0), POS_W'(0));
        drain_results();

        // A real rectangle again: its last pixel, one step past it on each
        // axis, and the origin, with zero pitch and pixel size zero.
        write_reg(REG_TARGET_HEIGHT, CFG_W'(100));
        send_position(POS_W'(2999), POS_W'(99));
        send_position(POS_W'(3000), POS_W'(5));
        send_position(POS_W'(7), POS_W'(100));
        send_position(POS_W'(0), POS_W'(0));
        drain_results();

        // The remaining pixel sizes.
        write_reg(REG_PIXEL_BYTES, CFG_W'(2));
        send_position(POS_W'(1234), POS_W'(50));
        drain_results();
        write_reg(REG_PIXEL_BYTES, CFG_W'(3));
        send_position(POS_W'(2999), POS_W'(0));
        drain_results();
        write_reg(REG_PIXEL_BYTES, CFG_W'(1));
        send_position(POS_W'(1500), POS_W'(98));
        drain_results();

        // Random phases, each with a fresh setting drawn while the block is
        // idle, followed by a run of positions.
        sent = 0;
        while (sent < RANDOM_POSITIONS) begin
            reconfigure();
            phase_len = $urandom_range(30, 90);
            run_positions(phase_len);
            sent += phase_len;
            drain_results();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
